FILE: rtl/core/slos_pkg.sv
// Shared types and constants for the segment line-of-sight block
`timescale 1ns / 1ps
package slos_pkg;

	// Default table depth and coordinate width
	localparam int DEF_MAX_CIRCLES = 16;
	localparam int DEF_COORD_BITS  = 16;

	// Fixed field widths
	localparam int CNT_W  = 5;
	localparam int IDX_W  = 4;
	localparam int SKIP_W = 5;

	// Projection parameter: 16 fraction bits plus the integer bit for 1.0
	localparam int FRAC_BITS = 16;
	localparam int U_W       = FRAC_BITS + 1;
	localparam int DIV_CNT_W = $clog2(FRAC_BITS);

	// Squaring works through the multiplier this many bits per cycle
	localparam int CHUNK_W = 16;

	// Radius squared is scaled by 2^(2*FRAC_BITS) to match the distance
	localparam int LIM_SHIFT = 2 * FRAC_BITS;

	// Item kinds
	localparam logic KIND_WRITE = 1'b0;
	localparam logic KIND_QUERY = 1'b1;

	// Commands from the controller to the datapath
	typedef struct packed {
		logic wr_tab;
		logic latch_seg;
		logic rd_tab;
		logic load_diff;
		logic load_prod;
		logic div_init;
		logic div_step;
		logic load_proj;
		logic load_dist;
		logic sq_step;
	} cmd_t;

	// Status from the datapath to the controller
	typedef struct packed {
		logic r_pos;
		logic need_div;
		logic sq_last;
		logic blocked;
	} sts_t;

endpackage

FILE: rtl/core/slos_datapath.sv
// Datapath: circle table, projection divider, distance squaring and compare
`timescale 1ns / 1ps
module slos_datapath #(
	parameter int MAX_CIRCLES = slos_pkg::DEF_MAX_CIRCLES,
	parameter int COORD_BITS  = slos_pkg::DEF_COORD_BITS,
	parameter int AW          = (MAX_CIRCLES > 1) ? $clog2(MAX_CIRCLES) : 1
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  slos_pkg::cmd_t                cmd,
	output slos_pkg::sts_t                sts,
	input  logic [AW-1:0]                 rd_addr,
	input  logic [slos_pkg::IDX_W-1:0]    entry_index,
	input  logic signed [COORD_BITS-1:0]  center_x,
	input  logic signed [COORD_BITS-1:0]  center_y,
	input  logic signed [COORD_BITS-1:0]  radius,
	input  logic signed [COORD_BITS-1:0]  start_x,
	input  logic signed [COORD_BITS-1:0]  start_y,
	input  logic signed [COORD_BITS-1:0]  end_x,
	input  logic signed [COORD_BITS-1:0]  end_y
);
	import slos_pkg::*;

	localparam int C     = COORD_BITS;
	localparam int DW    = C + 1;             // coordinate difference
	localparam int PW    = 2 * DW + 1;        // dot products
	localparam int XW    = DW + U_W + 1;      // scaled distance vector
	localparam int SQW   = 2 * XW;            // one square
	localparam int SW    = SQW + 1;           // sum of squares
	localparam int NSTEP = (XW + CHUNK_W - 1) / CHUNK_W;
	localparam int SCW   = (NSTEP > 1) ? $clog2(NSTEP) : 1;
	localparam logic [U_W-1:0] U_ONE = U_W'(1) << FRAC_BITS;

	// Circle table
	logic [3*C-1:0] mem_q [MAX_CIRCLES];
	logic [3*C-1:0] rd_q;

	// Query segment
	logic signed [C-1:0]  ax_q, ay_q;
	logic signed [DW-1:0] bax_q, bay_q;

	// Circle under test
	logic signed [DW-1:0] cax_q, cay_q;
	logic signed [C-1:0]  r_q;

	logic signed [PW-1:0] num_q;
	logic [PW-1:0]        den_q, rem_q;
	logic [U_W-1:0]       u_q;
	logic signed [XW-1:0] px_q, py_q;
	logic [XW-1:0]        mx_q, my_q;
	logic [SW-1:0]        lim_q;
	logic [SQW-1:0]       accx_q, accy_q;
	logic [SCW-1:0]       step_q;

	logic signed [C-1:0]  rd_cx, rd_cy, rd_r;
	logic [PW-1:0]        rem2;
	logic signed [XW-1:0] dx, dy;
	logic [XW-1:0]        shx, shy;
	logic [SW-1:0]        dist_sum;

	assign rd_cx = rd_q[3*C-1:2*C];
	assign rd_cy = rd_q[2*C-1:C];
	assign rd_r  = rd_q[C-1:0];

	// Write and read the table
	always_ff @(posedge clk) begin
		if (cmd.wr_tab && (8'(entry_index) < 8'(MAX_CIRCLES))) begin
			mem_q[AW'(entry_index)] <= {center_x, center_y, radius};
		end
		if (cmd.rd_tab) begin
			rd_q <= mem_q[rd_addr];
		end
	end

	// Division step: shift the remainder and subtract the length squared
	assign rem2 = {rem_q[PW-2:0], 1'b0};

	// Distance vector scaled by 2^16
	assign dx = (XW'(cax_q) <<< FRAC_BITS) - px_q;
	assign dy = (XW'(cay_q) <<< FRAC_BITS) - py_q;

	// Current multiplier chunk of each magnitude
	assign shx = mx_q >> (CHUNK_W * int'(step_q));
	assign shy = my_q >> (CHUNK_W * int'(step_q));

	assign dist_sum = {1'b0, accx_q} + {1'b0, accy_q};

	// Arithmetic registers
	always_ff @(posedge clk) begin
		if (cmd.latch_seg) begin
			ax_q  <= start_x;
			ay_q  <= start_y;
			bax_q <= DW'(end_x) - DW'(start_x);
			bay_q <= DW'(end_y) - DW'(start_y);
		end
		if (cmd.load_diff) begin
			cax_q <= DW'(rd_cx) - DW'(ax_q);
			cay_q <= DW'(rd_cy) - DW'(ay_q);
			r_q   <= rd_r;
		end
		if (cmd.load_prod) begin
			num_q <= PW'(cax_q * bax_q) + PW'(cay_q * bay_q);
			den_q <= PW'(bax_q * bax_q) + PW'(bay_q * bay_q);
		end
		if (cmd.div_init) begin
			rem_q <= PW'(num_q);
			if (den_q == '0 || num_q <= 0) begin
				u_q <= '0;
			end else if ($unsigned(num_q) >= den_q) begin
				u_q <= U_ONE;
			end else begin
				u_q <= '0;
			end
		end
		if (cmd.div_step) begin
			if (rem2 >= den_q) begin
				rem_q <= rem2 - den_q;
				u_q   <= {u_q[U_W-2:0], 1'b1};
			end else begin
				rem_q <= rem2;
				u_q   <= {u_q[U_W-2:0], 1'b0};
			end
		end
		if (cmd.load_proj) begin
			px_q <= XW'(bax_q * $signed({1'b0, u_q}));
			py_q <= XW'(bay_q * $signed({1'b0, u_q}));
		end
		if (cmd.load_dist) begin
			mx_q   <= dx[XW-1] ? XW'(-dx) : XW'(dx);
			my_q   <= dy[XW-1] ? XW'(-dy) : XW'(dy);
			lim_q  <= SW'(r_q * r_q) << LIM_SHIFT;
			accx_q <= '0;
			accy_q <= '0;
		end
		if (cmd.sq_step) begin
			accx_q <= accx_q + (SQW'(mx_q * shx[CHUNK_W-1:0]) << (CHUNK_W * int'(step_q)));
			accy_q <= accy_q + (SQW'(my_q * shy[CHUNK_W-1:0]) << (CHUNK_W * int'(step_q)));
		end
	end

	// Squaring step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
		end else if (cmd.load_dist) begin
			step_q <= '0;
		end else if (cmd.sq_step) begin
			step_q <= SCW'(step_q + 1'b1);
		end
	end

	assign sts.r_pos    = (r_q > 0);
	assign sts.need_div = (den_q != '0) && (num_q > 0) && ($unsigned(num_q) < den_q);
	assign sts.sq_last  = (step_q == SCW'(NSTEP - 1));
	assign sts.blocked  = (dist_sum < lim_q);

endmodule

FILE: rtl/core/slos_ctrl.sv
// Controller: item handshake, circle walk sequencer and result register
`timescale 1ns / 1ps
module slos_ctrl #(
	parameter int MAX_CIRCLES = slos_pkg::DEF_MAX_CIRCLES,
	parameter int AW          = (MAX_CIRCLES > 1) ? $clog2(MAX_CIRCLES) : 1
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic                        kind,
	input  logic [slos_pkg::SKIP_W-1:0] skip_first,
	input  logic [slos_pkg::SKIP_W-1:0] skip_second,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic                        path_clear,
	input  logic                        cfg_we,
	input  logic [slos_pkg::CNT_W-1:0]  cfg_wdata,
	output slos_pkg::cmd_t              cmd,
	input  slos_pkg::sts_t              sts,
	output logic [AW-1:0]               rd_addr
);
	import slos_pkg::*;

	localparam int KW = $clog2(MAX_CIRCLES + 1);

	typedef enum logic [3:0] {
		S_IDLE, S_FETCH, S_DIFF, S_PROD, S_SETUP, S_DIV,
		S_SCALE, S_DIST, S_SQR, S_CMP, S_DONE
	} state_t;

	state_t              state_q;
	logic [CNT_W-1:0]    count_q;
	logic [KW-1:0]       k_q, n_q;
	logic [SKIP_W-1:0]   s1_q, s2_q;
	logic [DIV_CNT_W-1:0] dcnt_q;
	logic                res_q;
	logic                out_valid_q, path_clear_q;
	logic                skip_hit, in_xfer;

	assign in_stall  = (state_q != S_IDLE);
	assign in_xfer   = in_valid && !in_stall;
	assign out_valid = out_valid_q;
	assign path_clear = path_clear_q;
	assign rd_addr   = k_q[AW-1:0];

	assign skip_hit = (!s1_q[SKIP_W-1] && (8'(k_q) == 8'(s1_q[SKIP_W-2:0]))) ||
	                  (!s2_q[SKIP_W-1] && (8'(k_q) == 8'(s2_q[SKIP_W-2:0])));

	// Decode datapath commands from the state
	always_comb begin
		cmd           = '0;
		cmd.wr_tab    = in_xfer && (kind == KIND_WRITE);
		cmd.latch_seg = in_xfer && (kind == KIND_QUERY);
		cmd.rd_tab    = (state_q == S_FETCH);
		cmd.load_diff = (state_q == S_DIFF);
		cmd.load_prod = (state_q == S_PROD);
		cmd.div_init  = (state_q == S_SETUP);
		cmd.div_step  = (state_q == S_DIV);
		cmd.load_proj = (state_q == S_SCALE);
		cmd.load_dist = (state_q == S_DIST);
		cmd.sq_step   = (state_q == S_SQR);
	end

	// Circle count register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cfg_we) begin
			count_q <= cfg_wdata;
		end
	end

	// Sequencer and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			k_q          <= '0;
			n_q          <= '0;
			s1_q         <= '0;
			s2_q         <= '0;
			dcnt_q       <= '0;
			res_q        <= 1'b0;
			out_valid_q  <= 1'b0;
			path_clear_q <= 1'b0;
		end else begin
			// drop the result once it has been taken, unless a new one replaces it
			if (out_valid_q && !out_stall && state_q != S_DONE) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_xfer && kind == KIND_QUERY) begin
						k_q  <= '0;
						n_q  <= (8'(count_q) > 8'(MAX_CIRCLES)) ? KW'(MAX_CIRCLES)
						                                         : KW'(count_q);
						s1_q <= skip_first;
						s2_q <= skip_second;
						state_q <= S_FETCH;
					end
				end
				S_FETCH: begin
					if (k_q >= n_q) begin
						res_q   <= 1'b1;
						state_q <= S_DONE;
					end else if (skip_hit) begin
						k_q <= KW'(k_q + 1'b1);
					end else begin
						state_q <= S_DIFF;
					end
				end
				S_DIFF: begin
					state_q <= S_PROD;
				end
				S_PROD: begin
					// nonpositive radius never blocks
					if (!sts.r_pos) begin
						k_q     <= KW'(k_q + 1'b1);
						state_q <= S_FETCH;
					end else begin
						state_q <= S_SETUP;
					end
				end
				S_SETUP: begin
					dcnt_q  <= '0;
					state_q <= sts.need_div ? S_DIV : S_SCALE;
				end
				S_DIV: begin
					dcnt_q <= DIV_CNT_W'(dcnt_q + 1'b1);
					if (dcnt_q == DIV_CNT_W'(FRAC_BITS - 1)) begin
						state_q <= S_SCALE;
					end
				end
				S_SCALE: begin
					state_q <= S_DIST;
				end
				S_DIST: begin
					state_q <= S_SQR;
				end
				S_SQR: begin
					if (sts.sq_last) begin
						state_q <= S_CMP;
					end
				end
				S_CMP: begin
					if (sts.blocked) begin
						res_q   <= 1'b0;
						state_q <= S_DONE;
					end else begin
						k_q     <= KW'(k_q + 1'b1);
						state_q <= S_FETCH;
					end
				end
				S_DONE: begin
					// hold until the result register is free
					if (!out_valid_q || !out_stall) begin
						out_valid_q  <= 1'b1;
						path_clear_q <= res_q;
						state_q      <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// A result only appears on leaving the done state
	a_out_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == S_DONE))
		else $error("result raised outside done state");

	// The walk never runs past the circles in use
	a_k_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_IDLE && state_q != S_DONE) |-> (k_q <= n_q))
		else $error("circle index beyond count");

	// Division always leaves to the scaling step
	a_div_exit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIV) |=> (state_q == S_DIV || state_q == S_SCALE))
		else $error("division left early");

	// A blocking circle ends the query with a blocked answer
	a_blocked: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CMP && sts.blocked) |=> (state_q == S_DONE && !res_q))
		else $error("blocked circle not reported");

endmodule

FILE: rtl/core/segment_line_of_sight.sv
// Top level of the segment line-of-sight block
//
//  channel   direction  handshake             payload
//  input     in         in_valid / in_stall    kind, entry_index, circle, segment, skips
//  output    out        out_valid / out_stall  path_clear
//  config    in         cfg_we                 cfg_wdata (circle count)
//
// A circle write is stored as it transfers. A query walks the circles in
// order: a skipped circle is passed over, one whose radius is not positive
// is dropped once its radius is read, and any other runs the bit-serial
// projection divider when the projection falls inside the segment, then the
// chunked squarer over NSTEP = ceil((COORD_BITS+19)/16) chunks of 16 bits.
// Reset clears the circle count; table entries hold nothing until written.
// The next item transfers while a finished result waits under out_stall.
`timescale 1ns / 1ps
module segment_line_of_sight #(
	parameter int MAX_CIRCLES = slos_pkg::DEF_MAX_CIRCLES,
	parameter int COORD_BITS  = slos_pkg::DEF_COORD_BITS
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic                          kind,
	input  logic [slos_pkg::IDX_W-1:0]    entry_index,
	input  logic signed [COORD_BITS-1:0]  center_x,
	input  logic signed [COORD_BITS-1:0]  center_y,
	input  logic signed [COORD_BITS-1:0]  radius,
	input  logic signed [COORD_BITS-1:0]  start_x,
	input  logic signed [COORD_BITS-1:0]  start_y,
	input  logic signed [COORD_BITS-1:0]  end_x,
	input  logic signed [COORD_BITS-1:0]  end_y,
	input  logic signed [slos_pkg::SKIP_W-1:0] skip_first,
	input  logic signed [slos_pkg::SKIP_W-1:0] skip_second,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic                          path_clear,
	input  logic                          cfg_we,
	input  logic [slos_pkg::CNT_W-1:0]    cfg_wdata
);
	import slos_pkg::*;

	localparam int AW = (MAX_CIRCLES > 1) ? $clog2(MAX_CIRCLES) : 1;

	cmd_t          cmd;
	sts_t          sts;
	logic [AW-1:0] rd_addr;

	// Sequencer
	slos_ctrl #(
		.MAX_CIRCLES (MAX_CIRCLES),
		.AW          (AW)
	) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.kind        (kind),
		.skip_first  (skip_first),
		.skip_second (skip_second),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.path_clear  (path_clear),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.cmd         (cmd),
		.sts         (sts),
		.rd_addr     (rd_addr)
	);

	// Arithmetic and circle table
	slos_datapath #(
		.MAX_CIRCLES (MAX_CIRCLES),
		.COORD_BITS  (COORD_BITS),
		.AW          (AW)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.rd_addr     (rd_addr),
		.entry_index (entry_index),
		.center_x    (center_x),
		.center_y    (center_y),
		.radius      (radius),
		.start_x     (start_x),
		.start_y     (start_y),
		.end_x       (end_x),
		.end_y       (end_y)
	);

endmodule
